// File: design/wet_pkg.sv
`default_nettype none

package wet_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_EXTENTS = 32;
    localparam int DEF_ADDR_BITS   = 23;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int IDX_W     = 5;
    localparam int CNT_OUT_W = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // cell commands
    localparam int CC_W = 3;
    localparam logic [CC_W-1:0] CC_HOLD  = 3'd0;
    localparam logic [CC_W-1:0] CC_FLAGS = 3'd1;  // latch extend-hit / at-or-above flags
    localparam logic [CC_W-1:0] CC_WRITE = 3'd2;  // extend, or insert with shift right
    localparam logic [CC_W-1:0] CC_PAIR  = 3'd3;  // latch touches-right-neighbor flag
    localparam logic [CC_W-1:0] CC_MERGE = 3'd4;  // merge first touching pair, shift left
    localparam logic [CC_W-1:0] CC_ERASE = 3'd5;  // remove one in-range extent, shift left

    typedef struct packed {
        logic [CC_W-1:0] cmd;
        logic            any_mark;  // some cell holds a write hit / touching pair
        logic            full;      // table holds MAX_EXTENTS extents
        logic            any_rng;   // some cell start lies in the erase range
    } wet_cell_ctl_t;

endpackage

`default_nettype wire

// File: design/wet_cell.sv
`default_nettype none

module wet_cell #(
    parameter int ADDR_BITS = wet_pkg::DEF_ADDR_BITS,
    localparam int SW = ADDR_BITS + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wet_pkg::wet_cell_ctl_t ctl,
    input  logic [ADDR_BITS-1:0]  addr,
    input  logic [SW-1:0]         len,
    input  logic [SW-1:0]         rng_end,
    input  logic                  occ,          // slot is below the extent count
    input  logic [ADDR_BITS-1:0]  left_start,
    input  logic [SW-1:0]         left_size,
    input  logic                  left_after,
    input  logic [ADDR_BITS-1:0]  right_start,
    input  logic [SW-1:0]         right_size,
    input  logic                  right_occ,
    input  logic                  seen_in,
    output logic [ADDR_BITS-1:0]  start,
    output logic [SW-1:0]         size,
    output logic                  after_out,
    output logic                  seen_out,
    output logic                  in_rng
);

    import wet_pkg::*;

    localparam logic [SW:0] SPACE = (SW+1)'(1) << ADDR_BITS;

    logic [ADDR_BITS-1:0] start_reg, start_next;
    logic [SW-1:0]        size_reg, size_next;
    logic                 ext_reg, ext_next;
    logic                 ge_reg, ge_next;
    logic                 pair_reg, pair_next;

    logic [SW-1:0] end_sum;
    logic          ext_hit;
    logic          ge;
    logic          pair;
    logic          at_after;
    logic          mark;

    // sum clipped to the size of the address space
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s > SPACE) ? SPACE[SW-1:0] : s[SW-1:0];
    endfunction

    assign end_sum  = {1'b0, start_reg} + size_reg;
    assign ext_hit  = occ && (end_sum == {1'b0, addr});
    assign ge       = occ && (start_reg >= addr);
    assign in_rng   = ge && ({1'b0, start_reg} < rng_end);
    assign pair     = occ && right_occ && ({1'b0, right_start} == end_sum);
    assign at_after = ge_reg || !occ;
    assign mark     = (ctl.cmd == CC_MERGE) ? pair_reg : ext_reg;

    assign after_out = at_after;
    assign seen_out  = seen_in | mark;
    assign start     = start_reg;
    assign size      = size_reg;

    always_comb
    begin
        start_next = start_reg;
        size_next  = size_reg;
        ext_next   = ext_reg;
        ge_next    = ge_reg;
        pair_next  = pair_reg;
        unique case (ctl.cmd)
            CC_FLAGS:
            begin
                ext_next = ext_hit;
                ge_next  = ge;
            end
            CC_WRITE:
            begin
                priority if (ctl.any_mark)
                begin
                    if (ext_reg && !seen_in)
                    begin
                        size_next = sat_add(size_reg, len);
                    end
                end
                else if (!ctl.full)
                begin
                    if (at_after && !left_after)
                    begin
                        start_next = addr;
                        size_next  = len;
                    end
                    else if (at_after)
                    begin
                        start_next = left_start;
                        size_next  = left_size;
                    end
                end
                else
                begin
                    // table full: the new extent is dropped
                    size_next = size_reg;
                end
            end
            CC_PAIR:
            begin
                pair_next = pair;
            end
            CC_MERGE:
            begin
                if (ctl.any_mark)
                begin
                    priority if (pair_reg && !seen_in)
                    begin
                        size_next = sat_add(size_reg, right_size);
                    end
                    else if (seen_in)
                    begin
                        start_next = right_start;
                        size_next  = right_size;
                    end
                    else
                    begin
                        size_next = size_reg;
                    end
                end
            end
            CC_ERASE:
            begin
                if (ctl.any_rng && ge)
                begin
                    start_next = right_start;
                    size_next  = right_size;
                end
            end
            default:
            begin
                start_next = start_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        size_reg  <= size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg  <= 1'b0;
            ge_reg   <= 1'b0;
            pair_reg <= 1'b0;
        end
        else
        begin
            ext_reg  <= ext_next;
            ge_reg   <= ge_next;
            pair_reg <= pair_next;
        end
    end

endmodule

`default_nettype wire

// File: design/written_extent_tracker.sv
`default_nettype none

// Channel  Dir  Fields (lowest bit first)
// -------  ---  --------------------------------------------------------------
// s_*      in   tuser: op; tdata: address, length, entry_index, zero pad
// m_*      out  tdata: entry_start, entry_size, entry_valid, entry_count,
//               overflow, zero pad
//
// No new item is taken until the last one is through to the output register.
// An erase removes one extent per cycle until none is left in its range.
// A write walks the cell chain: it latches compare flags, then extends or
// inserts, then latches neighbor-touch flags, then merges.
// Reset clears the extent count and the sequencer; cell contents are not
// reset since only slots below the count are ever looked at.
// A finished result waits in the output register; a new item is taken while
// it waits, but its own result is held back until the register frees up.
// Extent starts stay sorted, so insert position and erase run are found
// locally in each cell from its neighbor.
module written_extent_tracker #(
    parameter int MAX_EXTENTS = wet_pkg::DEF_MAX_EXTENTS,
    parameter int ADDR_BITS   = wet_pkg::DEF_ADDR_BITS,
    localparam int SW     = ADDR_BITS + 1,
    localparam int IN_RAW = ADDR_BITS + SW + wet_pkg::IDX_W,
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = ADDR_BITS + SW + 1 + wet_pkg::CNT_OUT_W + 1,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,   // address, length, entry_index
    input  logic [wet_pkg::OP_W-1:0]   s_tuser,   // op
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata    // start, size, valid, count, overflow
);

    import wet_pkg::*;

    localparam int CW   = $clog2(MAX_EXTENTS + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [SW-1:0] SPACE = SW'(1) << ADDR_BITS;

    // input field offsets
    localparam int IO_LEN = ADDR_BITS;
    localparam int IO_IDX = ADDR_BITS + SW;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLAGS = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_PAIR  = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_ERASE = 3'd5;
    localparam logic [2:0] S_READ  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [ADDR_BITS-1:0]  rd_start_reg, rd_start_next;
    logic [SW-1:0]         rd_size_reg, rd_size_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_RAW-1:0]    m_data_reg, m_data_next;

    // latched item
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [SW-1:0]         len_reg, len_next;
    logic [SW-1:0]         end_reg, end_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;

    logic [ADDR_BITS-1:0]  in_addr;
    logic [SW-1:0]         in_len;
    logic [SW-1:0]         in_len_clip;

    wet_cell_ctl_t         ctl;
    logic                  full;
    logic                  any_rng;
    logic                  rd_in_range;
    logic [ADDR_BITS-1:0]  rd_start_sel;
    logic [SW-1:0]         rd_size_sel;

    // chain wiring
    logic [ADDR_BITS-1:0]  c_start [MAX_EXTENTS];
    logic [SW-1:0]         c_size  [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] c_occ;
    logic [MAX_EXTENTS-1:0] c_after;
    logic [MAX_EXTENTS-1:0] c_seen;
    logic [MAX_EXTENTS-1:0] c_rng;
    logic [MAX_EXTENTS-1:0] c_sel;

    assign in_addr     = s_tdata[ADDR_BITS-1:0];
    assign in_len      = s_tdata[IO_LEN +: SW];
    assign in_len_clip = (in_len > SPACE) ? SPACE : in_len;

    assign full    = (count_reg == CW'(MAX_EXTENTS));
    assign any_rng = |c_rng;

    always_comb
    begin
        ctl.cmd      = CC_HOLD;
        ctl.any_mark = c_seen[MAX_EXTENTS-1];
        ctl.full     = full;
        ctl.any_rng  = any_rng;
        case (state_reg)
            S_FLAGS: ctl.cmd = CC_FLAGS;
            S_WRITE: ctl.cmd = CC_WRITE;
            S_PAIR:  ctl.cmd = CC_PAIR;
            S_MERGE: ctl.cmd = CC_MERGE;
            S_ERASE: ctl.cmd = CC_ERASE;
            default: ctl.cmd = CC_HOLD;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EXTENTS; gi++)
        begin : g_cell
            logic [ADDR_BITS-1:0] l_start, r_start;
            logic [SW-1:0]        l_size, r_size;
            logic                 l_after, l_seen, r_occ;

            assign c_occ[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign l_start = '0;
                assign l_size  = '0;
                assign l_after = 1'b0;
                assign l_seen  = 1'b0;
            end
            else
            begin : g_mid
                assign l_start = c_start[gi-1];
                assign l_size  = c_size[gi-1];
                assign l_after = c_after[gi-1];
                assign l_seen  = c_seen[gi-1];
            end

            if (gi == MAX_EXTENTS - 1)
            begin : g_last
                assign r_start = '0;
                assign r_size  = '0;
                assign r_occ   = 1'b0;
            end
            else
            begin : g_inner
                assign r_start = c_start[gi+1];
                assign r_size  = c_size[gi+1];
                assign r_occ   = c_occ[gi+1];
            end

            // read select: only slots reachable by the index field
            if (gi < (1 << IDX_W))
            begin : g_rd
                assign c_sel[gi] = (idx_reg == IDX_W'(gi));
            end
            else
            begin : g_nord
                assign c_sel[gi] = 1'b0;
            end

            wet_cell #(
                .ADDR_BITS(ADDR_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .addr       (addr_reg),
                .len        (len_reg),
                .rng_end    (end_reg),
                .occ        (c_occ[gi]),
                .left_start (l_start),
                .left_size  (l_size),
                .left_after (l_after),
                .right_start(r_start),
                .right_size (r_size),
                .right_occ  (r_occ),
                .seen_in    (l_seen),
                .start      (c_start[gi]),
                .size       (c_size[gi]),
                .after_out  (c_after[gi]),
                .seen_out   (c_seen[gi]),
                .in_rng     (c_rng[gi])
            );
        end
    endgenerate

    // AND-OR read select over the cells
    always_comb
    begin
        rd_start_sel = '0;
        rd_size_sel  = '0;
        for (int i = 0; i < MAX_EXTENTS; i++)
        begin
            if (c_sel[i])
            begin
                rd_start_sel = rd_start_sel | c_start[i];
                rd_size_sel  = rd_size_sel | c_size[i];
            end
        end
    end

    assign rd_in_range = (CMPW'(idx_reg) < CMPW'(count_reg));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        rd_valid_next = rd_valid_reg;
        rd_start_next = rd_start_reg;
        rd_size_next  = rd_size_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next     = in_addr;
                    len_next      = in_len_clip;
                    end_next      = {1'b0, in_addr} + in_len_clip;
                    idx_next      = s_tdata[IO_IDX +: IDX_W];
                    ovf_next      = 1'b0;
                    rd_valid_next = 1'b0;
                    rd_start_next = '0;
                    rd_size_next  = '0;
                    unique case (s_tuser)
                        OP_WRITE: state_next = S_FLAGS;
                        OP_ERASE: state_next = S_ERASE;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_FLAGS:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                priority if (ctl.any_mark)
                begin
                    count_next = count_reg;
                end
                else if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (ctl.any_mark)
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = S_DONE;
            end
            S_ERASE:
            begin
                // starts are sorted, so the in-range extents form one run
                if (any_rng)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                if (rd_in_range)
                begin
                    rd_valid_next = 1'b1;
                    rd_start_next = rd_start_sel;
                    rd_size_next  = rd_size_sel;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {ovf_reg, CNT_OUT_W'(count_reg), rd_valid_reg,
                                    rd_size_reg, rd_start_reg};
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
        rd_start_reg <= rd_start_next;
        rd_size_reg  <= rd_size_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_written_extent_tracker.sv
`default_nettype none

// Self-checking bench for the written extent tracker.
// Directed rows come first, then random bursts of writes, erases, reads and unused ops.
// Every accepted item runs through a local model of the extent table; the
// expected answer is queued and compared field by field with each answer
// taken off the master side.
module tb_written_extent_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import wet_pkg::*;

    localparam int SLOTS  = DEF_MAX_EXTENTS;
    localparam int AW     = DEF_ADDR_BITS;
    localparam int SZW    = AW + 1;
    localparam int S_W    = 56;               // 23 + 24 + 5 rounded up to bytes
    localparam int M_W    = 56;               // 23 + 24 + 1 + 6 + 1 rounded up
    localparam int N_RAND = 1200;
    localparam longint unsigned SPACE = 64'd1 << AW;
    // op code 3 has no meaning; the block must answer it like an empty read
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // answer fields, lowest bit last in the list
    typedef struct packed {
        logic                 ovf;
        logic [CNT_OUT_W-1:0] count;
        logic                 valid;
        logic [SZW-1:0]       size;
        logic [AW-1:0]        start;
    } ext_answer_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [AW-1:0]    addr;
        logic [SZW-1:0]   len;
        logic [IDX_W-1:0] idx;
        bit               typed;   // answer typed in below, not predicted
        ext_answer_t      known;
    } stim_row_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [S_W-1:0]  s_tdata;      // address, length, entry_index, zero pad
    logic [OP_W-1:0] s_tuser;      // op
    logic            m_tvalid;
    logic            m_tready;
    logic [M_W-1:0]  m_tdata;      // start, size, valid, count, overflow, pad

    written_extent_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ---- model of the extent table ----
    logic [AW-1:0]  ext_start [SLOTS];
    logic [SZW-1:0] ext_size  [SLOTS];
    int             ext_count = 0;

    ext_answer_t pending_answers [$];
    int          mismatches   = 0;
    int          answers_seen = 0;
    int          items_sent   = 0;
    bit          no_idle      = 1'b0;

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > SPACE) ? SPACE : s;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < ext_count; i++)
        begin
            ext_start[i] = ext_start[i + 1];
            ext_size[i]  = ext_size[i + 1];
        end
        ext_count--;
    endfunction

    // returns 1 when the new extent did not fit
    function automatic bit log_write(longint unsigned a, longint unsigned len);
        longint unsigned tail;
        int  pos;
        bit  hit;
        bit  lost;
        hit  = 1'b0;
        lost = 1'b0;
        // grow the lowest extent ending right at the write address
        for (int i = 0; i < ext_count; i++)
        begin
            tail = longint'(ext_start[i]) + longint'(ext_size[i]);
            if (a == tail)
            begin
                ext_size[i] = SZW'(sat_sum(ext_size[i], len));
                hit = 1'b1;
                break;
            end
        end
        if (!hit)
        begin
            pos = ext_count;
            for (int i = 0; i < ext_count; i++)
            begin
                if (longint'(ext_start[i]) >= a)
                begin
                    pos = i;
                    break;
                end
            end
            if (ext_count >= SLOTS)
                lost = 1'b1;
            else
            begin
                for (int i = ext_count; i > pos; i--)
                begin
                    ext_start[i] = ext_start[i - 1];
                    ext_size[i]  = ext_size[i - 1];
                end
                ext_start[pos] = a[AW-1:0];
                ext_size[pos]  = len[SZW-1:0];
                ext_count++;
            end
        end
        // merge only the first touching neighbor pair, even after a drop
        for (int i = 0; i + 1 < ext_count; i++)
        begin
            tail = longint'(ext_start[i]) + longint'(ext_size[i]);
            if (longint'(ext_start[i + 1]) == tail)
            begin
                ext_size[i] = SZW'(sat_sum(ext_size[i], ext_size[i + 1]));
                drop_slot(i + 1);
                break;
            end
        end
        return lost;
    endfunction

    function automatic void erase_span(longint unsigned a, longint unsigned len);
        longint unsigned stop;
        int i;
        stop = a + len;            // no wrap: range may run past the space
        i = 0;
        while (i < ext_count)
        begin
            if (longint'(ext_start[i]) >= a && longint'(ext_start[i]) < stop)
                drop_slot(i);
            else
                i++;
        end
    endfunction

    function automatic ext_answer_t predict_answer(stim_row_t r);
        ext_answer_t ans;
        longint unsigned len;
        ans = '0;
        len = longint'(r.len);
        if (len > SPACE)
            len = SPACE;
        case (r.op)
            OP_WRITE: ans.ovf = log_write(longint'(r.addr), len);
            OP_ERASE: erase_span(longint'(r.addr), len);
            OP_READ:
                if (int'(r.idx) < ext_count)
                begin
                    ans.start = ext_start[r.idx];
                    ans.size  = ext_size[r.idx];
                    ans.valid = 1'b1;
                end
            default: ;
        endcase
        ans.count = ext_count[CNT_OUT_W-1:0];
        return ans;
    endfunction

    function automatic ext_answer_t answer(longint unsigned st, longint unsigned sz,
                                           bit vld, int cnt, bit ovf);
        ext_answer_t a;
        a.start = st[AW-1:0];
        a.size  = sz[SZW-1:0];
        a.valid = vld;
        a.count = cnt[CNT_OUT_W-1:0];
        a.ovf   = ovf;
        return a;
    endfunction

    function automatic stim_row_t mk_row(logic [OP_W-1:0] op, longint unsigned a,
                                         longint unsigned len, int idx,
                                         bit typed, ext_answer_t known);
        stim_row_t r;
        r.op    = op;
        r.addr  = a[AW-1:0];
        r.len   = len[SZW-1:0];
        r.idx   = idx[IDX_W-1:0];
        r.typed = typed;
        r.known = known;
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at answer %0d, %s: got 0x%0h want 0x%0h",
                 answers_seen, what, got, want);
        mismatches++;
    endtask

    // ---- sender side ----
    // valid stays high across back-to-back items; it drops only in a gap
    task automatic send_item(stim_row_t r);
        ext_answer_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {4'b0, r.idx, r.len, r.addr};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_answer(r);
        pending_answers.push_back(r.typed ? r.known : predicted);
        items_sent++;
    endtask

    task automatic sender_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else if (pick < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // ---- receiver side: random ready plus one long hold-off ----
    initial
    begin : ready_gen
        int  pick;
        int  stretch;
        bit  held_off;
        m_tready = 1'b0;
        held_off = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && answers_seen >= 300)
            begin
                // sender keeps offering, so the block backs up and drops s_tready
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                m_tready <= 1'b1;
                stretch = $urandom_range(1, 40);
            end
            else
            begin
                m_tready <= 1'b0;
                if (pick < 90)
                    stretch = $urandom_range(1, 3);
                else if (pick < 97)
                    stretch = $urandom_range(4, 12);
                else
                    stretch = $urandom_range(20, 80);
            end
            repeat (stretch) @(posedge clk);
        end
    end

    // ---- answer checker ----
    always @(posedge clk)
    begin : answer_check
        ext_answer_t got;
        ext_answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = ext_answer_t'(m_tdata[$bits(ext_answer_t)-1:0]);
            if (pending_answers.size() == 0)
                flag_mismatch("answer with nothing pending", got, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (got.start !== want.start) flag_mismatch("entry_start", got.start, want.start);
                if (got.size  !== want.size)  flag_mismatch("entry_size", got.size, want.size);
                if (got.valid !== want.valid) flag_mismatch("entry_valid", got.valid, want.valid);
                if (got.count !== want.count) flag_mismatch("entry_count", got.count, want.count);
                if (got.ovf   !== want.ovf)   flag_mismatch("overflow", got.ovf, want.ovf);
            end
            answers_seen++;
        end
    end

    // ---- stimulus ----
    initial
    begin : stim
        stim_row_t dir_tab [$];
        stim_row_t r;
        longint unsigned a;
        longint unsigned len;
        longint unsigned tail;
        int kind;
        int pick;
        int burst;
        int j;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_WRITE;

        // empty table, unused op, erase of nothing, then a first write and its read back
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 0, 1, answer(0, 0, 0, 0, 0)));
        dir_tab.push_back(mk_row(OP_NONE, 23'h7FFFFF, 24'hFFFFFF, 31, 1,
                                 answer(0, 0, 0, 0, 0)));
        dir_tab.push_back(mk_row(OP_ERASE, 0, 24'hFFFFFF, 0, 1, answer(0, 0, 0, 0, 0)));
        dir_tab.push_back(mk_row(OP_WRITE, 0, 16, 0, 1, answer(0, 0, 0, 1, 0)));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 0, 1, answer(0, 16, 1, 1, 0)));
        // extend, zero length, insert before, extend that then merges
        dir_tab.push_back(mk_row(OP_WRITE, 16, 8, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_WRITE, 100, 0, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_WRITE, 50, 10, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_WRITE, 60, 40, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 1, 0, '0));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 31, 0, '0));
        // top address, length clipped to the space size
        dir_tab.push_back(mk_row(OP_WRITE, 23'h7FFFFF, 24'hFFFFFF, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 2, 0, '0));
        // erase whose end runs past the address space
        dir_tab.push_back(mk_row(OP_ERASE, 23'h7FFFF0, 24'hFFFFFF, 0, 0, '0));
        // extend that saturates
        dir_tab.push_back(mk_row(OP_WRITE, 23'h400000, 24'h3FFFF0, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_WRITE, 23'h7FFFF0, 24'h800000, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 1, 0, '0));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 2, 0, '0));
        // insert at address zero ahead of an extent already starting there
        dir_tab.push_back(mk_row(OP_WRITE, 0, 24'h800000, 5'h1F, 0, '0));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 1, 0, '0));
        dir_tab.push_back(mk_row(OP_ERASE, 0, 0, 0, 0, '0));
        dir_tab.push_back(mk_row(OP_ERASE, 0, 24'hFFFFFF, 0, 1, answer(0, 0, 0, 0, 0)));
        dir_tab.push_back(mk_row(OP_READ, 0, 0, 0, 1, answer(0, 0, 0, 0, 0)));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            send_item(dir_tab[k]);
            sender_gap();
        end

        // random bursts
        while (items_sent < dir_tab.size() + N_RAND)
        begin
            kind    = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 9) < 3);
            if (kind < 12)
            begin
                // clear the table, then fill it to capacity or past it with spaced, non-touching writes
                send_item(mk_row(OP_ERASE, 0, 24'hFFFFFF, $urandom_range(0, 31), 0, '0));
                sender_gap();
                a = longint'($urandom_range(0, 1000)) * 64;
                burst = $urandom_range(32, 36);
                for (int k = 0; k < burst; k++)
                begin
                    send_item(mk_row(OP_WRITE, a + k * 64, $urandom_range(0, 40),
                                     $urandom_range(0, 31), 0, '0));
                    sender_gap();
                end
                for (int k = 0; k < 4; k++)
                begin
                    send_item(mk_row(OP_READ, 0, 0, $urandom_range(0, 31), 0, '0));
                    sender_gap();
                end
            end
            else
            begin
                burst = $urandom_range(4, 20);
                for (int k = 0; k < burst; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (kind < 75)
                    begin
                        // small window so extents touch, extend and merge often
                        a = longint'($urandom_range(0, 63)) * 16;
                        case ($urandom_range(0, 5))
                            0: len = 0;
                            1: len = 16;
                            2: len = 32;
                            3: len = 48;
                            default: len = longint'($urandom_range(0, 100));
                        endcase
                    end
                    else
                    begin
                        a = longint'($urandom_range(0, 32'h7FFFFF));
                        len = ($urandom_range(0, 1) == 1)
                              ? longint'($urandom_range(0, 32'hFFFFFF))
                              : longint'($urandom_range(0, 4096));
                    end
                    if (pick < 55)
                    begin
                        if (ext_count > 0 && $urandom_range(0, 3) == 0)
                        begin
                            j = $urandom_range(0, ext_count - 1);
                            tail = longint'(ext_start[j]) + longint'(ext_size[j]);
                            if (tail < SPACE)
                                a = tail;
                        end
                        r = mk_row(OP_WRITE, a, len, $urandom_range(0, 31), 0, '0);
                    end
                    else if (pick < 70)
                    begin
                        if (kind < 75)
                            len = longint'($urandom_range(0, 256));
                        r = mk_row(OP_ERASE, a, len, $urandom_range(0, 31), 0, '0);
                    end
                    else if (pick < 95)
                    begin
                        j = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, ext_count);
                        if (j > 31)
                            j = 31;
                        r = mk_row(OP_READ, a, len, j, 0, '0);
                    end
                    else
                        r = mk_row(OP_NONE, a, len, $urandom_range(0, 31), 0, '0);
                    send_item(r);
                    sender_gap();
                end
            end
        end

        // drain, then allow for a last erase walking the whole table
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: written_extent_tracker.f
design/wet_pkg.sv
design/wet_cell.sv
design/written_extent_tracker.sv
verif/tb_written_extent_tracker.sv
